// ===== src/blpg_pkg.sv =====
// shared types, codes and constants for the bresenham line pixel generator
// no dependencies
package blpg_pkg;

  localparam int COORD_W = 9;
  localparam int COLOUR_W = 16;
  localparam int PIX_X_W = 8;
  localparam int ERR_W = 12;
  localparam int STATUS_W = 2;
  localparam int SCREEN_WIDTH_DEF = 240;
  localparam int SCREEN_HEIGHT_DEF = 320;
  localparam int QUEUE_DEPTH = 4;

  // input op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_PIXEL = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_START = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_IDLE = 2'd3;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_REJECT,
    CMD_ADVANCE
  } cmd_kind_t;

  // classified command passed from front to back
  typedef struct packed {
    cmd_kind_t             kind;
    logic                  swapped;
    logic [COORD_W-1:0]    major_pos;
    logic [COORD_W-1:0]    major_stop;
    logic [COORD_W-1:0]    minor_pos;
    logic                  minor_down;
    logic [COORD_W-1:0]    major_span;
    logic [COORD_W-1:0]    minor_span;
    logic [COLOUR_W-1:0]   colour;
  } cmd_t;

endpackage

// ===== src/blpg_front.sv =====
// front end: screen bounds check, steep test and endpoint ordering of a start beat
// depends on blpg_pkg
module blpg_front #(
  parameter int SCREEN_WIDTH = blpg_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = blpg_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                         op,
  input  logic [blpg_pkg::COORD_W-1:0] x_start,
  input  logic [blpg_pkg::COORD_W-1:0] y_start,
  input  logic [blpg_pkg::COORD_W-1:0] x_end,
  input  logic [blpg_pkg::COORD_W-1:0] y_end,
  input  logic [blpg_pkg::COLOUR_W-1:0] colour,
  output blpg_pkg::cmd_t               cmd
);
  import blpg_pkg::*;

  localparam logic [COORD_W:0] WIDTH_LIM = (COORD_W+1)'(SCREEN_WIDTH);
  localparam logic [COORD_W:0] HEIGHT_LIM = (COORD_W+1)'(SCREEN_HEIGHT);

  logic               off_screen;
  logic               steep;
  logic [COORD_W-1:0] dx, dy;
  logic [COORD_W-1:0] a1, b1, a2, b2;
  logic [COORD_W-1:0] lo_a, hi_a, lo_b, hi_b;

  // bounds check on both endpoints
  assign off_screen = ({1'b0, x_start} >= WIDTH_LIM) || ({1'b0, x_end} >= WIDTH_LIM) ||
                      ({1'b0, y_start} >= HEIGHT_LIM) || ({1'b0, y_end} >= HEIGHT_LIM);

  // spans and steep test
  assign dx = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
  assign dy = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
  assign steep = dy > dx;

  // pick major and minor axes
  assign a1 = steep ? y_start : x_start;
  assign b1 = steep ? x_start : y_start;
  assign a2 = steep ? y_end : x_end;
  assign b2 = steep ? x_end : y_end;

  // order endpoints so the major coordinate rises
  always_comb begin
    if (a1 > a2) begin
      lo_a = a2;
      lo_b = b2;
      hi_a = a1;
      hi_b = b1;
    end else begin
      lo_a = a1;
      lo_b = b1;
      hi_a = a2;
      hi_b = b2;
    end
  end

  // build command
  always_comb begin
    cmd = '0;
    if (op == OP_ADVANCE) begin
      cmd.kind = CMD_ADVANCE;
    end else if (off_screen) begin
      cmd.kind = CMD_REJECT;
    end else begin
      cmd.kind = CMD_START;
      cmd.swapped = steep;
      cmd.major_pos = lo_a;
      cmd.major_stop = hi_a;
      cmd.minor_pos = lo_b;
      cmd.minor_down = !(lo_b < hi_b);
      cmd.major_span = hi_a - lo_a;
      cmd.minor_span = (hi_b > lo_b) ? (hi_b - lo_b) : (lo_b - hi_b);
      cmd.colour = colour;
    end
  end

endmodule

// ===== src/blpg_cmd_queue.sv =====
// short command queue between front and back
// depends on blpg_pkg
module blpg_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  blpg_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output blpg_pkg::cmd_t rd_cmd
);
  import blpg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full = (count_r == DEPTH_CNT);
  assign rd_valid = (count_r != '0);
  assign rd_cmd = slot_r[rd_ptr_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && rd_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== src/blpg_back.sv =====
// back end: line state, error accumulator stepping and result register
// depends on blpg_pkg
module blpg_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  blpg_pkg::cmd_t                cmd,
  output logic                          cmd_take,
  output logic                          empty,
  input  logic                          pop,
  output logic [blpg_pkg::STATUS_W-1:0] status,
  output logic                          pixel_valid,
  output logic [blpg_pkg::PIX_X_W-1:0]  pixel_x,
  output logic [blpg_pkg::COORD_W-1:0]  pixel_y,
  output logic [blpg_pkg::COLOUR_W-1:0] pixel_colour,
  output logic                          last_pixel
);
  import blpg_pkg::*;

  // line state
  logic                       line_active_r, line_active_nxt;
  logic                       swapped_r;
  logic [COORD_W-1:0]         major_pos_r, major_stop_r, minor_pos_r;
  logic                       minor_down_r;
  logic [COORD_W-1:0]         major_span_r, minor_span_r;
  logic [COLOUR_W-1:0]        colour_r;
  logic signed [ERR_W-1:0]    err_r;

  // result register
  logic                       res_valid_r;
  logic [STATUS_W-1:0]        status_r;
  logic                       pixel_valid_r;
  logic [PIX_X_W-1:0]         pixel_x_r;
  logic [COORD_W-1:0]         pixel_y_r;
  logic [COLOUR_W-1:0]        pixel_colour_r;
  logic                       last_pixel_r;

  logic                       step;
  logic                       is_last;
  logic [COORD_W-1:0]         px, py;
  logic signed [ERR_W-1:0]    err_add, err_step;
  logic                       minor_move;

  assign cmd_take = cmd_valid && (!res_valid_r || pop);
  assign step = cmd_take && (cmd.kind == CMD_ADVANCE) && line_active_r;

  // pixel of the current position and next accumulator value
  assign is_last = (major_pos_r == major_stop_r);
  assign px = swapped_r ? minor_pos_r : major_pos_r;
  assign py = swapped_r ? major_pos_r : minor_pos_r;
  assign err_add = err_r + $signed({{(ERR_W-COORD_W-1){1'b0}}, minor_span_r, 1'b0});
  assign minor_move = (err_add >= $signed({{(ERR_W-COORD_W){1'b0}}, major_span_r}));
  assign err_step = minor_move ?
                    err_add - $signed({{(ERR_W-COORD_W-1){1'b0}}, major_span_r, 1'b0}) :
                    err_add;

  always_comb begin
    line_active_nxt = line_active_r;
    if (cmd_take) begin
      case (cmd.kind)
        CMD_START:   line_active_nxt = 1'b1;
        CMD_REJECT:  line_active_nxt = 1'b0;
        CMD_ADVANCE: if (line_active_r && is_last) line_active_nxt = 1'b0;
        default:     line_active_nxt = line_active_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      line_active_r <= line_active_nxt;
      if (cmd_take) begin
        res_valid_r <= 1'b1;
      end else if (pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // line registers: load on start, step on advance
  always_ff @(posedge clk) begin
    if (cmd_take && cmd.kind == CMD_START) begin
      swapped_r <= cmd.swapped;
      major_pos_r <= cmd.major_pos;
      major_stop_r <= cmd.major_stop;
      minor_pos_r <= cmd.minor_pos;
      minor_down_r <= cmd.minor_down;
      major_span_r <= cmd.major_span;
      minor_span_r <= cmd.minor_span;
      colour_r <= cmd.colour;
      err_r <= '0;
    end else if (step) begin
      major_pos_r <= major_pos_r + 1'b1;
      err_r <= err_step;
      if (minor_move) begin
        minor_pos_r <= minor_down_r ? minor_pos_r - 1'b1 : minor_pos_r + 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      pixel_valid_r <= 1'b0;
      pixel_x_r <= '0;
      pixel_y_r <= '0;
      pixel_colour_r <= '0;
      last_pixel_r <= 1'b0;
      case (cmd.kind)
        CMD_START:  status_r <= STAT_START;
        CMD_REJECT: status_r <= STAT_REJECT;
        CMD_ADVANCE: begin
          if (line_active_r) begin
            status_r <= STAT_PIXEL;
            pixel_valid_r <= 1'b1;
            pixel_x_r <= px[PIX_X_W-1:0];
            pixel_y_r <= py;
            pixel_colour_r <= colour_r;
            last_pixel_r <= is_last;
          end else begin
            status_r <= STAT_IDLE;
          end
        end
        default: status_r <= STAT_IDLE;
      endcase
    end
  end

  assign empty = !res_valid_r;
  assign status = status_r;
  assign pixel_valid = pixel_valid_r;
  assign pixel_x = pixel_x_r;
  assign pixel_y = pixel_y_r;
  assign pixel_colour = pixel_colour_r;
  assign last_pixel = last_pixel_r;

endmodule

// ===== src/bresenham_line_pixel_generator.sv =====
// a result passes through the command queue and then the result register on its way out
// throughput: one beat per cycle, start and advance alike, while results are popped;
// the back end's single accumulator step per cycle sets the pixel rate
// a four-entry command queue and one result register decouple input and output
// reset (rst_n low, synchronous) empties queue and result, and ends any active line
module bresenham_line_pixel_generator #(
  parameter int SCREEN_WIDTH = blpg_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = blpg_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_op,
  input  logic [blpg_pkg::COORD_W-1:0]  in_x_start,
  input  logic [blpg_pkg::COORD_W-1:0]  in_y_start,
  input  logic [blpg_pkg::COORD_W-1:0]  in_x_end,
  input  logic [blpg_pkg::COORD_W-1:0]  in_y_end,
  input  logic [blpg_pkg::COLOUR_W-1:0] in_colour,
  output logic                          empty,
  input  logic                          pop,
  output logic [blpg_pkg::STATUS_W-1:0] out_status,
  output logic                          out_pixel_valid,
  output logic [blpg_pkg::PIX_X_W-1:0]  out_pixel_x,
  output logic [blpg_pkg::COORD_W-1:0]  out_pixel_y,
  output logic [blpg_pkg::COLOUR_W-1:0] out_pixel_colour,
  output logic                          out_last_pixel
);
  import blpg_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic head_valid;
  logic head_take;

  // classify input beats
  blpg_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .op     (in_op),
    .x_start(in_x_start),
    .y_start(in_y_start),
    .x_end  (in_x_end),
    .y_end  (in_y_end),
    .colour (in_colour),
    .cmd    (front_cmd)
  );

  // command queue
  blpg_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_cmd  (front_cmd),
    .full    (full),
    .rd_en   (head_take),
    .rd_valid(head_valid),
    .rd_cmd  (head_cmd)
  );

  // execute commands
  blpg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (head_valid),
    .cmd         (head_cmd),
    .cmd_take    (head_take),
    .empty       (empty),
    .pop         (pop),
    .status      (out_status),
    .pixel_valid (out_pixel_valid),
    .pixel_x     (out_pixel_x),
    .pixel_y     (out_pixel_y),
    .pixel_colour(out_pixel_colour),
    .last_pixel  (out_last_pixel)
  );

endmodule

// ===== src/blpg_checker.sv =====
// port-level checks for the bresenham line pixel generator, bound to the top level
// depends on blpg_pkg and bresenham_line_pixel_generator
module blpg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          empty,
  input logic                          pop,
  input logic [blpg_pkg::STATUS_W-1:0] out_status,
  input logic                          out_pixel_valid,
  input logic [blpg_pkg::PIX_X_W-1:0]  out_pixel_x,
  input logic [blpg_pkg::COORD_W-1:0]  out_pixel_y,
  input logic [blpg_pkg::COLOUR_W-1:0] out_pixel_colour,
  input logic                          out_last_pixel
);
  import blpg_pkg::*;

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // pixel flag agrees with status
  a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_pixel_valid == (out_status == STAT_PIXEL)))
    else $error("pixel_valid disagrees with status");

  // non-pixel results carry zero pixel fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_pixel_valid) |->
      (out_pixel_x == '0 && out_pixel_y == '0 && out_pixel_colour == '0 && !out_last_pixel))
    else $error("non-pixel result with pixel fields set");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status) && $stable(out_pixel_x) &&
                          $stable(out_pixel_y) && $stable(out_last_pixel)))
    else $error("waiting result changed");

endmodule

bind bresenham_line_pixel_generator blpg_checker u_blpg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_status      (out_status),
  .out_pixel_valid (out_pixel_valid),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_pixel_colour(out_pixel_colour),
  .out_last_pixel  (out_last_pixel)
);

// ===== dv/bresenham_line_pixel_generator_test.sv =====
// self-checking testbench for the bresenham line pixel generator: directed corner
// cases, then random line traces and noise, each beat checked against a line tracer
// depends on blpg_pkg and bresenham_line_pixel_generator
`timescale 1ns / 1ps

module bresenham_line_pixel_generator_test;
  import blpg_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef logic [COORD_W-1:0] coord_t;

  // one result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                valid;
    logic [PIX_X_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } pixel_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic                in_op = OP_START;
  coord_t              in_x_start = '0;
  coord_t              in_y_start = '0;
  coord_t              in_x_end = '0;
  coord_t              in_y_end = '0;
  logic [COLOUR_W-1:0] in_colour = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_pixel_valid;
  logic [PIX_X_W-1:0]  out_pixel_x;
  coord_t              out_pixel_y;
  logic [COLOUR_W-1:0] out_pixel_colour;
  logic                out_last_pixel;

  // line tracer state
  logic                trace_on = 1'b0;
  logic                trace_swapped = 1'b0;
  coord_t              trace_major = '0;
  coord_t              trace_stop = '0;
  coord_t              trace_minor = '0;
  logic                trace_down = 1'b0;
  logic signed [ERR_W-1:0] trace_err = '0;
  coord_t              trace_major_span = '0;
  coord_t              trace_minor_span = '0;
  logic [COLOUR_W-1:0] trace_colour = '0;

  pixel_beat_t awaited_q[$];
  int          error_count = 0;
  int          beats_sent = 0;
  int          quiet_cycles = 0;
  int          pop_hold = 0;
  bit          in_idling = 1'b1;
  bit          out_idling = 1'b1;

  bresenham_line_pixel_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_x_start       (in_x_start),
    .in_y_start       (in_y_start),
    .in_x_end         (in_x_end),
    .in_y_end         (in_y_end),
    .in_colour        (in_colour),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_pixel_valid  (out_pixel_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic coord_t coord_gap(input coord_t a, input coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit on_screen(input coord_t xs, ys, xe, ye);
    return xs < SCREEN_WIDTH_DEF && ys < SCREEN_HEIGHT_DEF &&
           xe < SCREEN_WIDTH_DEF && ye < SCREEN_HEIGHT_DEF;
  endfunction

  // advance the line tracer by one input beat and return the beat it produces
  function automatic pixel_beat_t trace_step(input logic op, input coord_t xs, ys, xe, ye,
                                             input logic [COLOUR_W-1:0] col);
    pixel_beat_t beat;
    coord_t      a1, b1, a2, b2, tmp;
    logic        steep;
    int          acc;
    beat = '0;
    if (op == OP_START) begin
      if (!on_screen(xs, ys, xe, ye)) begin
        trace_on = 1'b0;
        beat.status = STAT_REJECT;
      end else begin
        steep = coord_gap(ye, ys) > coord_gap(xe, xs);
        if (steep) begin
          a1 = ys; b1 = xs; a2 = ye; b2 = xe;
        end else begin
          a1 = xs; b1 = ys; a2 = xe; b2 = ye;
        end
        // order endpoints so the major coordinate rises
        if (a1 > a2) begin
          tmp = a1; a1 = a2; a2 = tmp;
          tmp = b1; b1 = b2; b2 = tmp;
        end
        trace_swapped = steep;
        trace_major = a1;
        trace_stop = a2;
        trace_minor = b1;
        trace_down = !(b1 < b2);
        trace_major_span = a2 - a1;
        trace_minor_span = coord_gap(b2, b1);
        trace_err = '0;
        trace_colour = col;
        trace_on = 1'b1;
        beat.status = STAT_START;
      end
    end else if (!trace_on) begin
      beat.status = STAT_IDLE;
    end else begin
      beat.status = STAT_PIXEL;
      beat.valid = 1'b1;
      beat.px = trace_swapped ? trace_minor[PIX_X_W-1:0] : trace_major[PIX_X_W-1:0];
      beat.py = trace_swapped ? trace_major : trace_minor;
      beat.colour = trace_colour;
      beat.last = (trace_major == trace_stop);
      // doubled-error accumulator step
      acc = int'(trace_err) + 2 * int'(trace_minor_span);
      if (acc >= int'(trace_major_span)) begin
        trace_minor = trace_down ? trace_minor - 1'b1 : trace_minor + 1'b1;
        acc = acc - 2 * int'(trace_major_span);
      end
      trace_err = acc[ERR_W-1:0];
      trace_major = trace_major + 1'b1;
      if (beat.last) trace_on = 1'b0;
    end
    return beat;
  endfunction

  function automatic void check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // result checking, input tracing, watchdog and pop stalls
  always @(posedge clk) begin : result_monitor
    pixel_beat_t got;
    pixel_beat_t want;
    logic        moved;
    moved = 1'b0;
    if (rst_n) begin
      // output beat first, then the input beat of the same edge
      if (pop && !empty) begin
        moved = 1'b1;
        got = '{out_status, out_pixel_valid, out_pixel_x, out_pixel_y,
                out_pixel_colour, out_last_pixel};
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual status %0h",
                   $time, got.status);
          error_count++;
        end else begin
          want = awaited_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("pixel_valid", 32'(want.valid), 32'(got.valid));
          check_field("pixel_x", 32'(want.px), 32'(got.px));
          check_field("pixel_y", 32'(want.py), 32'(got.py));
          check_field("pixel_colour", 32'(want.colour), 32'(got.colour));
          check_field("last_pixel", 32'(want.last), 32'(got.last));
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        awaited_q.push_back(trace_step(in_op, in_x_start, in_y_start, in_x_end, in_y_end,
                                       in_colour));
      end
      // watchdog on cycles with no beat on either side
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bresenham_line_pixel_generator verification failed");
        $finish;
      end
    end
    // consumer stalls in bursts of random length
    if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (out_idling && $urandom_range(0, 7) == 0) begin
      pop_hold = $urandom_range(0, 12);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // send one input beat and wait until it is taken
  task automatic send_beat(input logic op, input coord_t xs, ys, xe, ye,
                           input logic [COLOUR_W-1:0] col);
    int gap;
    if (in_idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_op <= op;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end <= xe;
    in_y_end <= ye;
    in_colour <= col;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
  endtask

  // advance beat with random content in the ignored fields
  task automatic advance_beat();
    send_beat(OP_ADVANCE, coord_t'($urandom_range(0, 511)), coord_t'($urandom_range(0, 511)),
              coord_t'($urandom_range(0, 511)), coord_t'($urandom_range(0, 511)),
              COLOUR_W'($urandom_range(0, 65535)));
  endtask

  task automatic test_advance_idle();
    advance_beat();
  endtask

  task automatic test_corner_points();
    send_beat(OP_START, 239, 319, 239, 319, 16'hffff);
    advance_beat();
    advance_beat();
    send_beat(OP_START, 0, 0, 0, 0, 16'h0000);
    advance_beat();
  endtask

  task automatic test_off_screen();
    send_beat(OP_START, 240, 10, 10, 10, 16'h1234);
    send_beat(OP_START, 511, 511, 511, 511, 16'hffff);
    // a rejected start ends the line in progress
    send_beat(OP_START, 1, 1, 5, 2, 16'h00ff);
    advance_beat();
    send_beat(OP_START, 1, 1, 5, 320, 16'hff00);
    advance_beat();
  endtask

  task automatic test_octants();
    // shallow, reversed endpoints, minor coordinate falling
    send_beat(OP_START, 5, 3, 2, 5, 16'ha5a5);
    repeat (4) advance_beat();
    // steep, axes swapped
    send_beat(OP_START, 2, 2, 3, 5, 16'h5a5a);
    repeat (4) advance_beat();
  endtask

  task automatic test_line_replace();
    send_beat(OP_START, 100, 200, 104, 195, 16'h0f0f);
    advance_beat();
    send_beat(OP_START, 50, 60, 53, 60, 16'hf0f0);
    repeat (2) advance_beat();
  endtask

  function automatic coord_t clamp_coord(input int v);
    return (v < 0) ? 9'd0 : (v > 511) ? 9'd511 : coord_t'(v);
  endfunction

  // well-formed line traces with random endpoints, sometimes cut short or overrun
  task automatic test_random_lines(input int upto);
    coord_t xs, ys, xe, ye;
    int     n;
    while (beats_sent < upto) begin
      case ($urandom_range(0, 15))
        0, 1: begin
          xs = coord_t'($urandom_range(0, 511)); ys = coord_t'($urandom_range(0, 511));
          xe = coord_t'($urandom_range(0, 511)); ye = coord_t'($urandom_range(0, 511));
        end
        2: begin
          xs = coord_t'($urandom_range(0, 239)); ys = coord_t'($urandom_range(0, 319));
          xe = coord_t'($urandom_range(0, 239)); ye = coord_t'($urandom_range(0, 319));
        end
        default: begin
          // short lines, often starting at a screen border
          if ($urandom_range(0, 3) == 0)
            xs = coord_t'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                               : $urandom_range(236, 239));
          else
            xs = coord_t'($urandom_range(0, 239));
          if ($urandom_range(0, 3) == 0)
            ys = coord_t'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                               : $urandom_range(316, 319));
          else
            ys = coord_t'($urandom_range(0, 319));
          xe = clamp_coord(int'(xs) + int'($urandom_range(0, 32)) - 16);
          ye = clamp_coord(int'(ys) + int'($urandom_range(0, 32)) - 16);
        end
      endcase
      send_beat(OP_START, xs, ys, xe, ye, COLOUR_W'($urandom_range(0, 65535)));
      n = 0;
      if (on_screen(xs, ys, xe, ye))
        n = ((coord_gap(xe, xs) > coord_gap(ye, ys)) ? coord_gap(xe, xs)
                                                      : coord_gap(ye, ys)) + 1;
      case ($urandom_range(0, 9))
        0: n = $urandom_range(0, n);
        1: n = n + $urandom_range(1, 3);
        default: ;
      endcase
      repeat (n) advance_beat();
    end
  endtask

  // unstructured beats: random ops and fields
  task automatic test_noise(input int upto);
    while (beats_sent < upto) begin
      if ($urandom_range(0, 1))
        advance_beat();
      else
        send_beat(OP_START, coord_t'($urandom_range(0, 511)), coord_t'($urandom_range(0, 511)),
                  coord_t'($urandom_range(0, 511)), coord_t'($urandom_range(0, 511)),
                  COLOUR_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_advance_idle();
    test_corner_points();
    test_off_screen();
    test_octants();
    test_line_replace();
    test_random_lines(1000);
    test_noise(1150);
    // last stretch runs without idling on either side
    in_idling = 1'b0;
    out_idling = 1'b0;
    test_random_lines(1350);
    push <= 1'b0;

    while (awaited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("bresenham_line_pixel_generator verification clean");
    end else begin
      $display("bresenham_line_pixel_generator verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/blpg_pkg.sv
src/blpg_front.sv
src/blpg_cmd_queue.sv
src/blpg_back.sv
src/bresenham_line_pixel_generator.sv
src/blpg_checker.sv
dv/bresenham_line_pixel_generator_test.sv
